// File: sv/dead_reckoning_odometry_defines.svh
// ---------------------------------------------------------------------------
// Odometry assertion macros
// Shared concurrent assertion forms for the checker.
// ---------------------------------------------------------------------------
`ifndef DEAD_RECKONING_ODOMETRY_DEFINES_SVH
`define DEAD_RECKONING_ODOMETRY_DEFINES_SVH

// same-cycle implication, disabled in reset
`define DRO_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("odometry check failed");

// next-cycle implication, disabled in reset
`define DRO_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("odometry check failed");

`endif

// File: sv/dro_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Odometry package
// Shared widths, codes, constants and the CORDIC arctangent table.
// ---------------------------------------------------------------------------
package dro_pkg;

	localparam int HISTORY = 8;
	localparam int SLOT_W = (HISTORY > 1) ? $clog2(HISTORY) : 1;
	localparam int ANGLE_W = 16;
	localparam int TIME_W = 32;
	localparam int RING_W = ANGLE_W + TIME_W;

	localparam int CFG_DATA_W = 24;
	localparam int CFG_IDX_W = 1;
	localparam int DIST_W = 24;
	localparam int TICK_W = 20;
	localparam logic [DIST_W-1:0] DIST_RESET = 24'd643;
	localparam logic [TICK_W-1:0] TICK_RESET = 20'd1000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DIST_PER_COUNT = 1'b0,
		REG_TICK_FREQUENCY = 1'b1
	} cfg_reg_t;

	localparam logic OP_UPDATE = 1'b0;
	localparam logic OP_RESET = 1'b1;

	localparam int POS_W = 48;
	localparam int RATE_W = 32;

	// CORDIC
	localparam int CORDIC_STEPS = 16;
	localparam int STEP_W = 4;
	localparam int CORDIC_W = 34;
	localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

	// shared multiplier and datapath
	localparam int MUL_A_W = 35;
	localparam int MUL_B_W = 25;
	localparam int PROD_W = MUL_A_W + MUL_B_W;
	localparam int T_W = 49;
	localparam int ACC_W = 61;

	// rate divider
	localparam int NUM_W = 37;
	localparam int DEN_W = 33;
	localparam int DCNT_W = $clog2(NUM_W + 1);

	typedef struct packed {
		logic done;
		logic signed [ANGLE_W-1:0] sin_q15;
		logic signed [ANGLE_W-1:0] cos_q15;
	} sincos_t;

	typedef struct packed {
		logic done;
		logic [NUM_W-1:0] quot;
	} div_result_t;

	// arctangent of 2^-i in units of 2^-32 turn
	function automatic logic signed [CORDIC_W-1:0] atan_turn(input logic [STEP_W-1:0] i);
		logic signed [CORDIC_W-1:0] v;
		begin
			case (i)
				4'd0: v = 34'sd536870912;
				4'd1: v = 34'sd316933406;
				4'd2: v = 34'sd167458907;
				4'd3: v = 34'sd85004756;
				4'd4: v = 34'sd42667331;
				4'd5: v = 34'sd21354465;
				4'd6: v = 34'sd10679838;
				4'd7: v = 34'sd5340245;
				4'd8: v = 34'sd2670163;
				4'd9: v = 34'sd1335087;
				4'd10: v = 34'sd667544;
				4'd11: v = 34'sd333772;
				4'd12: v = 34'sd166886;
				4'd13: v = 34'sd83443;
				4'd14: v = 34'sd41722;
				default: v = 34'sd20861;
			endcase
			return v;
		end
	endfunction

endpackage

// File: sv/dro_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Odometry channel interfaces
// Valid/ready channels for sample words and pose words.
// ---------------------------------------------------------------------------
interface dro_sample_if;
	logic valid;
	logic ready;
	logic operation;
	logic interval_positive;
	logic [31:0] count_x;
	logic [31:0] count_y;
	logic signed [dro_pkg::ANGLE_W-1:0] yaw_angle;
	logic [dro_pkg::TIME_W-1:0] timestamp;

	modport source (output valid, operation, interval_positive, count_x, count_y,
		yaw_angle, timestamp, input ready);
	modport sink (input valid, operation, interval_positive, count_x, count_y,
		yaw_angle, timestamp, output ready);
endinterface

interface dro_pose_if;
	logic valid;
	logic ready;
	logic signed [dro_pkg::POS_W-1:0] pos_x;
	logic signed [dro_pkg::POS_W-1:0] pos_y;
	logic signed [dro_pkg::ANGLE_W-1:0] heading;
	logic signed [dro_pkg::RATE_W-1:0] angular_rate;
	logic rate_valid;

	modport source (output valid, pos_x, pos_y, heading, angular_rate, rate_valid,
		input ready);
	modport sink (input valid, pos_x, pos_y, heading, angular_rate, rate_valid,
		output ready);
endinterface

// File: sv/dro_ring_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Ring RAM
// Simple dual-port synchronous RAM, one write and one registered read.
// ---------------------------------------------------------------------------
module dro_ring_ram #(
	parameter int ADDR_W = 3,
	parameter int DATA_W = 48,
	parameter int DEPTH = 8
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: sv/dro_cordic.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Iterative CORDIC
// Sine and cosine in Q1.15 of a binary angle, one rotation per cycle.
// ---------------------------------------------------------------------------
module dro_cordic (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  logic signed [dro_pkg::ANGLE_W-1:0]     angle,
	output dro_pkg::sincos_t                       result
);

	typedef enum logic [1:0] {CS_IDLE, CS_RUN, CS_OUT} cs_state_t;

	localparam int RND_W = dro_pkg::CORDIC_W + 1;

	cs_state_t state_q;
	logic [dro_pkg::STEP_W-1:0] step_q;
	logic flip_q;
	logic signed [dro_pkg::CORDIC_W-1:0] x_q, y_q, z_q;
	dro_pkg::sincos_t result_q;

	logic signed [dro_pkg::ANGLE_W:0] a_ext, a_fold;
	logic fold;
	logic signed [dro_pkg::CORDIC_W-1:0] x_sh, y_sh, atan_v;
	logic signed [RND_W-1:0] x_rnd, y_rnd;

	// round half up to Q1.15, negate for the folded half, saturate
	function automatic logic signed [dro_pkg::ANGLE_W-1:0] finish(
		input logic signed [dro_pkg::CORDIC_W-1:0] v, input logic neg);
		logic signed [RND_W-1:0] r;
		begin
			r = (RND_W'(v) + RND_W'(16384)) >>> 15;
			if (neg) begin
				r = -r;
			end
			if (r > RND_W'(32767)) begin
				return 16'sh7fff;
			end else if (r < -RND_W'(32768)) begin
				return 16'sh8000;
			end
			return r[dro_pkg::ANGLE_W-1:0];
		end
	endfunction

	always_comb begin
		a_ext = {angle[dro_pkg::ANGLE_W-1], angle};
		fold = 1'b1;
		if (a_ext > 17'sd16384) begin
			a_fold = a_ext - 17'sd32768;
		end else if (a_ext < -17'sd16384) begin
			a_fold = a_ext + 17'sd32768;
		end else begin
			a_fold = a_ext;
			fold = 1'b0;
		end
		x_sh = x_q >>> step_q;
		y_sh = y_q >>> step_q;
		atan_v = dro_pkg::atan_turn(step_q);
		x_rnd = RND_W'(x_q);
		y_rnd = RND_W'(y_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
			step_q <= '0;
			flip_q <= 1'b0;
			x_q <= '0;
			y_q <= '0;
			z_q <= '0;
			result_q <= '0;
		end else begin
			result_q.done <= 1'b0;
			unique case (state_q)
				CS_IDLE: begin
					if (start) begin
						x_q <= dro_pkg::CORDIC_GAIN;
						y_q <= '0;
						// angle in 2^-32 turn: sign-extended fold times 2^16
						z_q <= {a_fold[dro_pkg::ANGLE_W], a_fold, 16'b0};
						flip_q <= fold;
						step_q <= '0;
						state_q <= CS_RUN;
					end
				end
				CS_RUN: begin
					if (!z_q[dro_pkg::CORDIC_W-1]) begin
						x_q <= x_q - y_sh;
						y_q <= y_q + x_sh;
						z_q <= z_q - atan_v;
					end else begin
						x_q <= x_q + y_sh;
						y_q <= y_q - x_sh;
						z_q <= z_q + atan_v;
					end
					step_q <= step_q + 1'b1;
					if (step_q == dro_pkg::STEP_W'(dro_pkg::CORDIC_STEPS - 1)) begin
						state_q <= CS_OUT;
					end
				end
				CS_OUT: begin
					result_q.cos_q15 <= finish(x_rnd[dro_pkg::CORDIC_W-1:0], flip_q);
					result_q.sin_q15 <= finish(y_rnd[dro_pkg::CORDIC_W-1:0], flip_q);
					result_q.done <= 1'b1;
					state_q <= CS_IDLE;
				end
				default: state_q <= CS_IDLE;
			endcase
		end
	end

	assign result = result_q;

endmodule

// File: sv/dro_divider.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Radix-2 divider
// Unsigned restoring division, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module dro_divider (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [dro_pkg::NUM_W-1:0]    numer,
	input  logic [dro_pkg::DEN_W-1:0]    denom,
	output dro_pkg::div_result_t         result
);

	typedef enum logic {DS_IDLE, DS_RUN} ds_state_t;

	localparam int REM_W = dro_pkg::DEN_W + 1;

	ds_state_t state_q;
	logic [dro_pkg::DCNT_W-1:0] cnt_q;
	logic [dro_pkg::NUM_W-1:0] num_q;
	logic [dro_pkg::DEN_W-1:0] den_q;
	logic [REM_W-1:0] rem_q;
	logic done_q;

	logic [REM_W-1:0] rem_sh;
	logic take;

	always_comb begin
		rem_sh = {rem_q[REM_W-2:0], num_q[dro_pkg::NUM_W-1]};
		take = (rem_sh >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DS_IDLE;
			cnt_q <= '0;
			num_q <= '0;
			den_q <= '0;
			rem_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				DS_IDLE: begin
					if (start) begin
						num_q <= numer;
						den_q <= denom;
						rem_q <= '0;
						cnt_q <= '0;
						state_q <= DS_RUN;
					end
				end
				DS_RUN: begin
					rem_q <= take ? (rem_sh - {1'b0, den_q}) : rem_sh;
					num_q <= {num_q[dro_pkg::NUM_W-2:0], take};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == dro_pkg::DCNT_W'(dro_pkg::NUM_W - 1)) begin
						done_q <= 1'b1;
						state_q <= DS_IDLE;
					end
				end
				default: state_q <= DS_IDLE;
			endcase
		end
	end

	assign result.done = done_q;
	assign result.quot = num_q;

endmodule

// File: sv/dead_reckoning_odometry.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Dead-reckoning odometry
// Two tracking wheels rotated by an IMU heading, plus heading-rate estimate.
// ---------------------------------------------------------------------------
// One sample word in, one pose word out. A reset or no-op word (interval not
// positive) goes from acceptance to the done state and from there into the
// output register once it is free; the input is ready again as the pose word
// is loaded. An update word runs the 16-step CORDIC, ten slots of the one
// shared 35x25 multiplier, and, once the heading ring has filled and the tick
// difference is nonzero, the 37-step radix-2 divider for the angular rate;
// the finished word then may wait in the done state for the output register
// to free up. A new sample is taken as soon as the sequencer is back in idle,
// while the last pose word may still wait in the output register. Heading
// and timestamp history live in a HISTORY deep RAM: the new entry is written
// at the current slot while the oldest entry (the next slot) is read in the
// same cycle, so the two never collide. The RAM needs no clearing; its data
// is used only after a full lap since the last reset word. Configuration
// writes land directly in the two registers and must only happen while the
// block is idle.
// ---------------------------------------------------------------------------
module dead_reckoning_odometry (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write,
	input  logic [dro_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [dro_pkg::CFG_DATA_W-1:0]       cfg_data,
	dro_sample_if.sink                           sample,
	dro_pose_if.source                           pose
);

	typedef enum logic [2:0] {ST_IDLE, ST_CORDIC, ST_MUL, ST_DIV, ST_DONE} state_t;

	localparam int MSTEP_W = 4;
	localparam logic [MSTEP_W-1:0] MSTEP_LAST = 4'd9;
	localparam int ACC_MAXW = dro_pkg::ACC_W;
	localparam logic signed [ACC_MAXW-1:0] POS_MAX_A = {{(ACC_MAXW-dro_pkg::POS_W+1){1'b0}},
		{(dro_pkg::POS_W-1){1'b1}}};
	localparam logic signed [ACC_MAXW-1:0] POS_MIN_A = -POS_MAX_A - ACC_MAXW'(1);

	// configuration
	logic [dro_pkg::DIST_W-1:0] dist_q;
	logic [dro_pkg::TICK_W-1:0] tick_q;

	// architectural state
	state_t state_q;
	logic [31:0] last_x_q, last_y_q;
	logic signed [dro_pkg::POS_W-1:0] pos_x_q, pos_y_q;
	logic signed [dro_pkg::ANGLE_W-1:0] heading_q;
	logic signed [dro_pkg::RATE_W-1:0] rate_q;
	logic [dro_pkg::SLOT_W-1:0] slot_q;
	logic full_q;

	// per-update working registers
	logic signed [31:0] dcx_q, dcy_q;
	logic [dro_pkg::TIME_W-1:0] ts_q;
	logic do_rate_q;
	logic [MSTEP_W-1:0] mstep_q;
	logic signed [dro_pkg::T_W-1:0] tx_q, ty_q;
	logic signed [dro_pkg::ACC_W-1:0] acc_x_q, acc_y_q;
	logic [16:0] rmag_q;
	logic rneg_q;
	logic [dro_pkg::TIME_W-1:0] dt_q;

	// output register
	logic pose_valid_q;
	logic signed [dro_pkg::POS_W-1:0] out_x_q, out_y_q;
	logic signed [dro_pkg::ANGLE_W-1:0] out_head_q;
	logic signed [dro_pkg::RATE_W-1:0] out_rate_q;
	logic out_full_q;

	// shared multiplier, product registered
	logic signed [dro_pkg::MUL_A_W-1:0] mul_a;
	logic signed [dro_pkg::MUL_B_W-1:0] mul_b;
	logic signed [dro_pkg::PROD_W-1:0] prod_s1;

	// ring RAM
	logic accept, upd_accept;
	logic [dro_pkg::SLOT_W-1:0] oldest;
	logic [dro_pkg::RING_W-1:0] ring_rdata;
	logic signed [dro_pkg::ANGLE_W-1:0] old_angle;
	logic [dro_pkg::TIME_W-1:0] old_time;

	// submodule links
	dro_pkg::sincos_t sc;
	dro_pkg::div_result_t dv;
	logic cordic_start, div_start;
	logic [dro_pkg::NUM_W-1:0] div_num;
	logic [dro_pkg::DEN_W-1:0] div_den;

	// heading difference across the ring
	logic signed [dro_pkg::ANGLE_W:0] adiff;
	logic signed [dro_pkg::ANGLE_W+1:0] awrap;
	logic [dro_pkg::ANGLE_W+1:0] amag;

	// scaled-step rounding terms
	logic signed [dro_pkg::ACC_W-1:0] prod_acc, lo_round;
	logic [dro_pkg::RATE_W-1:0] rate_sat;

	assign accept = sample.valid && sample.ready;
	assign upd_accept = accept && (sample.operation == dro_pkg::OP_UPDATE)
		&& sample.interval_positive;
	assign sample.ready = (state_q == ST_IDLE);

	assign oldest = (slot_q == dro_pkg::SLOT_W'(dro_pkg::HISTORY - 1)) ? '0 : slot_q + 1'b1;
	assign old_angle = ring_rdata[dro_pkg::RING_W-1:dro_pkg::TIME_W];
	assign old_time = ring_rdata[dro_pkg::TIME_W-1:0];

	dro_ring_ram #(
		.ADDR_W(dro_pkg::SLOT_W),
		.DATA_W(dro_pkg::RING_W),
		.DEPTH(dro_pkg::HISTORY)
	) u_ring (
		.clk(clk),
		.we(upd_accept),
		.waddr(slot_q),
		.wdata({sample.yaw_angle, sample.timestamp}),
		.re(upd_accept),
		.raddr(oldest),
		.rdata(ring_rdata)
	);

	assign cordic_start = upd_accept;

	dro_cordic u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.start(cordic_start),
		.angle(sample.yaw_angle),
		.result(sc)
	);

	// rate = (2*|d|*f + dt) / (2*dt), i.e. rounded half away from zero
	assign div_start = (state_q == ST_MUL) && (mstep_q == MSTEP_LAST) && do_rate_q
		&& (dt_q != '0);
	assign div_num = {prod_s1[dro_pkg::NUM_W-2:0], 1'b0} + dro_pkg::NUM_W'(dt_q);
	assign div_den = {dt_q, 1'b0};

	dro_divider u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.numer(div_num),
		.denom(div_den),
		.result(dv)
	);

	// multiplier operand schedule
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (mstep_q)
			4'd0: begin
				mul_a = dro_pkg::MUL_A_W'(dcx_q);
				mul_b = dro_pkg::MUL_B_W'(sc.cos_q15);
			end
			4'd1: begin
				mul_a = dro_pkg::MUL_A_W'(dcy_q);
				mul_b = dro_pkg::MUL_B_W'(sc.sin_q15);
			end
			4'd2: begin
				mul_a = dro_pkg::MUL_A_W'(dcx_q);
				mul_b = dro_pkg::MUL_B_W'(sc.sin_q15);
			end
			4'd3: begin
				mul_a = dro_pkg::MUL_A_W'(dcy_q);
				mul_b = dro_pkg::MUL_B_W'(sc.cos_q15);
			end
			4'd4: begin
				mul_a = dro_pkg::MUL_A_W'(tx_q >>> 15);
				mul_b = $signed({1'b0, dist_q});
			end
			4'd5: begin
				mul_a = $signed({20'b0, tx_q[14:0]});
				mul_b = $signed({1'b0, dist_q});
			end
			4'd6: begin
				mul_a = dro_pkg::MUL_A_W'(ty_q >>> 15);
				mul_b = $signed({1'b0, dist_q});
			end
			4'd7: begin
				mul_a = $signed({20'b0, ty_q[14:0]});
				mul_b = $signed({1'b0, dist_q});
			end
			4'd8: begin
				mul_a = $signed({18'b0, rmag_q});
				mul_b = $signed({5'b0, tick_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
	end

	always_comb begin
		prod_acc = dro_pkg::ACC_W'(prod_s1);
		lo_round = (prod_acc + dro_pkg::ACC_W'(16384)) >>> 15;

		// wrap into [-half turn, +half turn]
		adiff = {heading_q[dro_pkg::ANGLE_W-1], heading_q}
			- {old_angle[dro_pkg::ANGLE_W-1], old_angle};
		awrap = dro_pkg::ANGLE_W'(0) + (dro_pkg::ANGLE_W+2)'(adiff);
		if (adiff > 17'sd32768) begin
			awrap = (dro_pkg::ANGLE_W+2)'(adiff) - 18'sd65536;
		end else if (adiff < -17'sd32768) begin
			awrap = (dro_pkg::ANGLE_W+2)'(adiff) + 18'sd65536;
		end
		amag = awrap[dro_pkg::ANGLE_W+1] ? -awrap : awrap;

		// signed saturation of the rounded quotient
		if (rneg_q) begin
			rate_sat = (dv.quot > dro_pkg::NUM_W'(33'h0_8000_0000))
				? 32'h8000_0000 : -dv.quot[dro_pkg::RATE_W-1:0];
		end else begin
			rate_sat = (dv.quot > dro_pkg::NUM_W'(32'h7fff_ffff))
				? 32'h7fff_ffff : dv.quot[dro_pkg::RATE_W-1:0];
		end
	end

	function automatic logic signed [dro_pkg::POS_W-1:0] sat_pos(
		input logic signed [dro_pkg::ACC_W-1:0] v);
		begin
			if (v > POS_MAX_A) begin
				return POS_MAX_A[dro_pkg::POS_W-1:0];
			end else if (v < POS_MIN_A) begin
				return POS_MIN_A[dro_pkg::POS_W-1:0];
			end
			return v[dro_pkg::POS_W-1:0];
		end
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			dist_q <= dro_pkg::DIST_RESET;
			tick_q <= dro_pkg::TICK_RESET;
			last_x_q <= '0;
			last_y_q <= '0;
			pos_x_q <= '0;
			pos_y_q <= '0;
			heading_q <= '0;
			rate_q <= '0;
			slot_q <= '0;
			full_q <= 1'b0;
			dcx_q <= '0;
			dcy_q <= '0;
			ts_q <= '0;
			do_rate_q <= 1'b0;
			mstep_q <= '0;
			tx_q <= '0;
			ty_q <= '0;
			acc_x_q <= '0;
			acc_y_q <= '0;
			rmag_q <= '0;
			rneg_q <= 1'b0;
			dt_q <= '0;
			pose_valid_q <= 1'b0;
			out_x_q <= '0;
			out_y_q <= '0;
			out_head_q <= '0;
			out_rate_q <= '0;
			out_full_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					dro_pkg::REG_DIST_PER_COUNT: dist_q <= cfg_data[dro_pkg::DIST_W-1:0];
					dro_pkg::REG_TICK_FREQUENCY: tick_q <= cfg_data[dro_pkg::TICK_W-1:0];
					default: ;
				endcase
			end

			if (pose.ready) begin
				pose_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (sample.operation == dro_pkg::OP_RESET) begin
							last_x_q <= sample.count_x;
							last_y_q <= sample.count_y;
							pos_x_q <= '0;
							pos_y_q <= '0;
							heading_q <= '0;
							rate_q <= '0;
							slot_q <= '0;
							full_q <= 1'b0;
							state_q <= ST_DONE;
						end else if (sample.interval_positive) begin
							// deltas modulo 2^32 read as signed
							dcx_q <= $signed(sample.count_x - last_x_q);
							dcy_q <= $signed(sample.count_y - last_y_q);
							last_x_q <= sample.count_x;
							last_y_q <= sample.count_y;
							heading_q <= sample.yaw_angle;
							ts_q <= sample.timestamp;
							full_q <= full_q
								| (slot_q == dro_pkg::SLOT_W'(dro_pkg::HISTORY - 1));
							do_rate_q <= full_q
								| (slot_q == dro_pkg::SLOT_W'(dro_pkg::HISTORY - 1));
							slot_q <= oldest;
							mstep_q <= '0;
							state_q <= ST_CORDIC;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_CORDIC: begin
					if (sc.done) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					mstep_q <= mstep_q + 1'b1;
					case (mstep_q)
						4'd1: tx_q <= prod_s1[dro_pkg::T_W-1:0];
						4'd2: tx_q <= tx_q - prod_s1[dro_pkg::T_W-1:0];
						4'd3: ty_q <= prod_s1[dro_pkg::T_W-1:0];
						4'd4: ty_q <= ty_q + prod_s1[dro_pkg::T_W-1:0];
						4'd5: acc_x_q <= dro_pkg::ACC_W'(pos_x_q) + prod_acc;
						4'd6: acc_x_q <= acc_x_q + lo_round;
						4'd7: begin
							acc_y_q <= dro_pkg::ACC_W'(pos_y_q) + prod_acc;
							rmag_q <= amag[16:0];
							rneg_q <= awrap[dro_pkg::ANGLE_W+1];
							dt_q <= ts_q - old_time;
						end
						4'd8: begin
							acc_y_q <= acc_y_q + lo_round;
							pos_x_q <= sat_pos(acc_x_q);
						end
						4'd9: begin
							pos_y_q <= sat_pos(acc_y_q);
							state_q <= div_start ? ST_DIV : ST_DONE;
						end
						default: ;
					endcase
				end
				ST_DIV: begin
					if (dv.done) begin
						rate_q <= $signed(rate_sat);
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!pose_valid_q || pose.ready) begin
						pose_valid_q <= 1'b1;
						out_x_q <= pos_x_q;
						out_y_q <= pos_y_q;
						out_head_q <= heading_q;
						out_rate_q <= rate_q;
						out_full_q <= full_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign pose.valid = pose_valid_q;
	assign pose.pos_x = out_x_q;
	assign pose.pos_y = out_y_q;
	assign pose.heading = out_head_q;
	assign pose.angular_rate = out_rate_q;
	assign pose.rate_valid = out_full_q;

endmodule

// File: sv/dro_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Odometry port checker
// Port-level assertions, bound to the top level.
// ---------------------------------------------------------------------------
`include "dead_reckoning_odometry_defines.svh"

module dro_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_valid,
	input logic        s_ready,
	input logic        p_valid,
	input logic        p_ready,
	input logic [31:0] p_rate,
	input logic        p_rate_valid
);

	// a stalled pose word holds
	`DRO_ASSERT_NEXT(a_pose_hold, p_valid && !p_ready, p_valid && $stable(p_rate))

	// one sample word at a time: busy right after acceptance
	`DRO_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready)

	// no rate before the heading ring has filled
	`DRO_ASSERT_NOW(a_rate_needs_ring, p_valid && !p_rate_valid, p_rate == 32'd0)

endmodule

bind dead_reckoning_odometry dro_checker u_dro_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_valid(sample.valid),
	.s_ready(sample.ready),
	.p_valid(pose.valid),
	.p_ready(pose.ready),
	.p_rate(pose.angular_rate),
	.p_rate_valid(pose.rate_valid)
);
